// ----- design/sarg_pkg.sv -----
// shared types and constants for the stepper acceleration ramp generator
// no dependencies; used by every module of the block by scoped names
`default_nettype none

package sarg_pkg;

	// fixed field widths
	localparam int CN_BITS       = 32;  // ramp interval, unsigned fixed point
	localparam int TICK_BITS     = 24;  // whole-microsecond interval and tick counter
	localparam int MAG_BITS      = 31;  // magnitude of the ramp index
	localparam int DIV_BITS      = 33;  // divider operand and quotient width
	localparam int IO_POS_BITS   = 32;  // position and target width at the ports
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 32;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_BITS-1:0] REG_INITIAL_INTERVAL = 1'b0;
	localparam logic [CFG_IDX_BITS-1:0] REG_MIN_INTERVAL     = 1'b1;

	localparam logic [CN_BITS-1:0] INITIAL_INTERVAL_RESET = 32'd0;
	localparam logic [CN_BITS-1:0] MIN_INTERVAL_RESET     = 32'd256;

	localparam logic [MAG_BITS-1:0]  MAG_MAX  = {MAG_BITS{1'b1}};
	localparam logic [TICK_BITS-1:0] TICK_MAX = {TICK_BITS{1'b1}};

	// outcome of the ramp decision
	typedef enum logic [1:0] {
		KIND_STOP  = 2'd0,
		KIND_START = 2'd1,
		KIND_HOLD  = 2'd2,
		KIND_DIV   = 2'd3
	} kind_t;

	// controller to datapath
	typedef struct packed {
		logic take;       // latch target of the accepted request
		logic span;       // distance to target
		logic absd;       // distance magnitude and sign flags
		logic decide;     // direction decision and ramp outcome
		logic apply;      // stop, start or hold outcome
		logic div_start;  // launch 2cn / (4n+1)
		logic update;     // new cn and n from quotient
		logic load;       // whole-microsecond interval from cn
		logic tick;       // count one microsecond, maybe step
		logic emit;       // capture the result
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic  changed;
		logic  fired;
		kind_t kind;
		logic  div_done;
	} sts_t;

endpackage

`default_nettype wire

// ----- design/stepper_accel_ramp_generator.sv -----
// top level of the stepper acceleration ramp generator
// depends on sarg_pkg, sarg_ctrl, sarg_dp (which holds sarg_divider)
//
// Each request is one microsecond tick carrying the absolute target position,
// and it returns exactly one result: step pulse, direction, position after the
// tick, running flag and the magnitude of the ramp index n. A new target
// recomputes the ramp, the tick counter then decides whether a step fires,
// and a fired step recomputes the ramp again. Step intervals follow
// cn := cn -/+ 2cn/(4n+1) in unsigned fixed point with INTERVAL_FRAC_BITS
// fraction bits. A recompute that updates cn runs the shared restoring divider,
// which produces one quotient bit per clock over 33 bits; a recompute that
// only stops, starts or holds the ramp does not use it. Requests are handled
// one at a time; the next request is taken while a finished result still
// waits in the output register. Configuration is written through
// cfg_valid/cfg_index/cfg_data and is always ready; write it only while the
// block is idle.
`default_nettype none

module stepper_accel_ramp_generator #(
	parameter int POSITION_BITS      = 32,
	parameter int INTERVAL_FRAC_BITS = 8
) (
	input  wire logic                                    clk,
	input  wire logic                                    arst_n,

	// configuration write channel
	input  wire logic                                    cfg_valid,
	output logic                                         cfg_ready,
	input  wire logic [sarg_pkg::CFG_IDX_BITS-1:0]       cfg_index,
	input  wire logic [sarg_pkg::CFG_DATA_BITS-1:0]      cfg_data,

	// tick requests
	input  wire logic                                    in_valid,
	output logic                                         in_stall,
	input  wire logic signed [sarg_pkg::IO_POS_BITS-1:0] target_position,

	// results
	output logic                                         out_valid,
	input  wire logic                                    out_stall,
	output logic                                         step_pulse,
	output logic                                         direction_out,
	output logic signed [sarg_pkg::IO_POS_BITS-1:0]      position,
	output logic                                         running,
	output logic [sarg_pkg::MAG_BITS-1:0]                steps_to_stop
);

	// configuration registers
	logic [sarg_pkg::CN_BITS-1:0] c0_q;
	logic [sarg_pkg::CN_BITS-1:0] cmin_q;

	sarg_pkg::cmd_t cmd;
	sarg_pkg::sts_t sts;
	logic           ctrl_idle;
	logic           out_free;

	// datapath view of the result
	logic                               dp_pulse;
	logic                               dp_dir;
	logic [sarg_pkg::IO_POS_BITS-1:0]   dp_pos;
	logic                               dp_run;
	logic [sarg_pkg::MAG_BITS-1:0]      dp_mag;

	// output register
	logic                               out_valid_q;
	logic                               pulse_q;
	logic                               dir_q;
	logic [sarg_pkg::IO_POS_BITS-1:0]   pos_q;
	logic                               run_q;
	logic [sarg_pkg::MAG_BITS-1:0]      mag_q;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c0_q   <= sarg_pkg::INITIAL_INTERVAL_RESET;
			cmin_q <= sarg_pkg::MIN_INTERVAL_RESET;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				sarg_pkg::REG_INITIAL_INTERVAL: c0_q   <= cfg_data;
				sarg_pkg::REG_MIN_INTERVAL:     cmin_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// the result slot is free when empty or being taken this edge
	assign out_free = !out_valid_q || !out_stall;

	sarg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.out_free (out_free),
		.sts      (sts),
		.cmd      (cmd),
		.idle     (ctrl_idle)
	);

	sarg_dp #(
		.POSITION_BITS      (POSITION_BITS),
		.INTERVAL_FRAC_BITS (INTERVAL_FRAC_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.target_in (target_position),
		.c0        (c0_q),
		.cmin      (cmin_q),
		.o_pulse   (dp_pulse),
		.o_dir     (dp_dir),
		.o_pos     (dp_pos),
		.o_run     (dp_run),
		.o_mag     (dp_mag)
	);

	// a request is taken only while the sequencer waits for one
	assign in_stall = !ctrl_idle;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			pulse_q <= dp_pulse;
			dir_q   <= dp_dir;
			pos_q   <= dp_pos;
			run_q   <= dp_run;
			mag_q   <= dp_mag;
		end
	end

	assign out_valid     = out_valid_q;
	assign step_pulse    = pulse_q;
	assign direction_out = dir_q;
	assign position      = signed'(pos_q);
	assign running       = run_q;
	assign steps_to_stop = mag_q;

endmodule

`default_nettype wire

// ----- design/sarg_divider.sv -----
// iterative restoring divider, one quotient bit per clock
// depends on sarg_pkg for the operand width
`default_nettype none

module sarg_divider (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [sarg_pkg::DIV_BITS-1:0] dividend,
	input  wire logic [sarg_pkg::DIV_BITS-1:0] divisor,
	output logic                              busy,
	output logic                              done,
	output logic [sarg_pkg::DIV_BITS-1:0]      quotient
);

	localparam int W        = sarg_pkg::DIV_BITS;
	localparam int CNT_BITS = $clog2(W + 1);
	localparam logic [CNT_BITS-1:0] ITERS = CNT_BITS'(W);

	logic [W-1:0]        rem_q;
	logic [W-1:0]        quo_q;
	logic [W-1:0]        dsr_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                busy_q;
	logic                done_q;

	logic [W:0]   rem_sh;
	logic [W+1:0] diff;
	logic         ge;
	logic [W-1:0] rem_nxt;
	logic [W-1:0] quo_nxt;

	always_comb begin
		rem_sh  = {rem_q, quo_q[W-1]};
		diff    = {1'b0, rem_sh} - {2'b00, dsr_q};
		ge      = ~diff[W+1];
		rem_nxt = ge ? diff[W-1:0] : rem_sh[W-1:0];
		quo_nxt = {quo_q[W-2:0], ge};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= ITERS;
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_BITS'(1);
				if (cnt_q == CNT_BITS'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dsr_q <= divisor;
		end else if (busy_q) begin
			rem_q <= rem_nxt;
			quo_q <= quo_nxt;
		end
	end

	assign busy     = busy_q;
	assign done     = done_q;
	assign quotient = quo_q;

endmodule

`default_nettype wire

// ----- design/sarg_dp.sv -----
// ramp datapath: position, target, ramp index and interval registers
// depends on sarg_pkg and sarg_divider
`default_nettype none

module sarg_dp #(
	parameter int POSITION_BITS      = 32,
	parameter int INTERVAL_FRAC_BITS = 8
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire sarg_pkg::cmd_t                       cmd,
	output sarg_pkg::sts_t                            sts,
	input  wire logic [sarg_pkg::IO_POS_BITS-1:0]     target_in,
	input  wire logic [sarg_pkg::CN_BITS-1:0]         c0,
	input  wire logic [sarg_pkg::CN_BITS-1:0]         cmin,
	output logic                                      o_pulse,
	output logic                                      o_dir,
	output logic [sarg_pkg::IO_POS_BITS-1:0]          o_pos,
	output logic                                      o_run,
	output logic [sarg_pkg::MAG_BITS-1:0]             o_mag
);

	localparam int PB     = POSITION_BITS;
	localparam int FB     = INTERVAL_FRAC_BITS;
	localparam int WIDE   = (PB > sarg_pkg::IO_POS_BITS) ? PB : sarg_pkg::IO_POS_BITS;
	localparam int DW     = PB + 1;
	localparam int CW     = (DW > sarg_pkg::MAG_BITS) ? DW : sarg_pkg::MAG_BITS;
	localparam int CMP_W  = (sarg_pkg::TICK_BITS + FB > sarg_pkg::CN_BITS) ?
		sarg_pkg::TICK_BITS + FB : sarg_pkg::CN_BITS;
	localparam int CNB    = sarg_pkg::CN_BITS;
	localparam int TB     = sarg_pkg::TICK_BITS;
	localparam int MB     = sarg_pkg::MAG_BITS;

	// architectural state
	logic [PB-1:0]  pos_q;
	logic [PB-1:0]  tgt_q;
	logic           n_neg_q;
	logic [MB-1:0]  n_mag_q;
	logic [CNB-1:0] cn_q;
	logic [TB-1:0]  step_us_q;
	logic [TB-1:0]  elapsed_q;
	logic           cw_q;

	// per-request working registers
	logic                 chg_q;
	logic                 fired_q;
	logic signed [DW-1:0] dist_q;
	logic [DW-1:0]        absd_q;
	logic                 dpos_q;
	logic                 dzero_q;
	logic                 nd_neg_q;
	sarg_pkg::kind_t      kind_q;

	logic [WIDE-1:0]   tgt_wide;
	logic [PB-1:0]     tgt_trunc;
	logic [WIDE-1:0]   pos_wide;
	logic signed [DW-1:0] dist_nxt;

	logic              npos;
	logic              big;
	logic              toward;
	logic              flip;
	logic              nd_neg;
	logic              accel_ok;
	sarg_pkg::kind_t   kind_nxt;

	logic [sarg_pkg::DIV_BITS-1:0] den;
	logic [sarg_pkg::DIV_BITS-1:0] quo;
	logic                          div_busy;
	logic                          div_done;
	logic [CNB:0]                  cn_sum;
	logic [MB-1:0]                 mag_dec;
	logic [TB-1:0]                 el_inc;
	logic                          fire;

	function automatic logic [TB-1:0] to_ticks(input logic [CNB-1:0] c);
		logic [CNB-1:0] whole;
		whole = c >> FB;
		return (|whole[CNB-1:TB]) ? sarg_pkg::TICK_MAX : whole[TB-1:0];
	endfunction

	always_comb begin
		tgt_wide  = WIDE'(signed'(target_in));
		tgt_trunc = tgt_wide[PB-1:0];
		pos_wide  = WIDE'(signed'(pos_q));
		dist_nxt  = DW'(signed'(tgt_q)) - DW'(signed'(pos_q));
	end

	// direction decision and ramp outcome
	always_comb begin
		npos     = !n_neg_q && (n_mag_q != '0);
		big      = CW'(n_mag_q) >= CW'(absd_q);
		toward   = dpos_q ? cw_q : !cw_q;
		flip     = !dzero_q && (npos ? (big || !toward) : (n_neg_q && !big && toward));
		nd_neg   = n_neg_q ^ flip;
		accel_ok = (CMP_W'(step_us_q) << FB) > CMP_W'(cmin);
		if (dzero_q && (n_neg_q || n_mag_q <= MB'(1)))
			kind_nxt = sarg_pkg::KIND_STOP;
		else if (n_mag_q == '0)
			kind_nxt = sarg_pkg::KIND_START;
		else if (nd_neg || accel_ok)
			kind_nxt = sarg_pkg::KIND_DIV;
		else
			kind_nxt = sarg_pkg::KIND_HOLD;
	end

	// 4n+1 for accel, 4|n|-1 for decel
	always_comb begin
		mag_dec = n_mag_q - MB'(1);
		den     = nd_neg_q ? {mag_dec, 2'b11} : {n_mag_q, 2'b01};
		cn_sum  = {1'b0, cn_q} + quo[CNB:0];
		el_inc  = (elapsed_q == sarg_pkg::TICK_MAX) ? elapsed_q : elapsed_q + TB'(1);
		fire    = (step_us_q != '0) && (el_inc >= step_us_q);
	end

	sarg_divider u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend ({cn_q, 1'b0}),
		.divisor  (den),
		.busy     (div_busy),
		.done     (div_done),
		.quotient (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q     <= '0;
			tgt_q     <= '0;
			n_neg_q   <= 1'b0;
			n_mag_q   <= '0;
			cn_q      <= '0;
			step_us_q <= '0;
			elapsed_q <= '0;
			cw_q      <= 1'b0;
			chg_q     <= 1'b0;
			fired_q   <= 1'b0;
			kind_q    <= sarg_pkg::KIND_STOP;
		end else begin
			if (cmd.take) begin
				tgt_q <= tgt_trunc;
				chg_q <= tgt_trunc != tgt_q;
			end
			if (cmd.decide)
				kind_q <= kind_nxt;
			if (cmd.apply) begin
				case (kind_q)
					sarg_pkg::KIND_STOP: begin
						step_us_q <= '0;
						n_mag_q   <= '0;
						n_neg_q   <= 1'b0;
					end
					sarg_pkg::KIND_START: begin
						cn_q      <= c0;
						cw_q      <= dpos_q;
						step_us_q <= to_ticks(c0);
						n_mag_q   <= MB'(1);
						n_neg_q   <= 1'b0;
					end
					sarg_pkg::KIND_HOLD: begin
						n_neg_q <= nd_neg_q;
					end
					default: begin
					end
				endcase
			end
			if (cmd.update) begin
				if (nd_neg_q) begin
					cn_q    <= cn_sum[CNB] ? {CNB{1'b1}} : cn_sum[CNB-1:0];
					n_mag_q <= mag_dec;
					n_neg_q <= mag_dec != '0;
				end else begin
					cn_q    <= cn_q - quo[CNB-1:0];
					n_mag_q <= (n_mag_q == sarg_pkg::MAG_MAX) ? n_mag_q : n_mag_q + MB'(1);
					n_neg_q <= 1'b0;
				end
			end
			if (cmd.load)
				step_us_q <= to_ticks(cn_q);
			if (cmd.tick) begin
				fired_q <= fire;
				if (fire) begin
					pos_q     <= cw_q ? pos_q + PB'(1) : pos_q - PB'(1);
					elapsed_q <= '0;
				end else begin
					elapsed_q <= el_inc;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.span)
			dist_q <= dist_nxt;
		if (cmd.absd) begin
			absd_q  <= dist_q[DW-1] ? DW'(-dist_q) : DW'(dist_q);
			dpos_q  <= !dist_q[DW-1] && (dist_q != '0);
			dzero_q <= dist_q == '0;
		end
		if (cmd.decide)
			nd_neg_q <= nd_neg;
	end

	always_comb begin
		sts.changed  = chg_q;
		sts.fired    = fired_q;
		sts.kind     = kind_q;
		sts.div_done = div_done;
	end

	assign o_pulse = fired_q;
	assign o_dir   = cw_q;
	assign o_pos   = pos_wide[sarg_pkg::IO_POS_BITS-1:0];
	assign o_run   = step_us_q != '0;
	assign o_mag   = n_mag_q;

	// a negative ramp index never has zero magnitude
	a_n_norm: assert property (@(posedge clk) disable iff (!arst_n)
		n_neg_q |-> n_mag_q != '0)
		else $error("ramp index negative zero");

	// a step restarts the tick count
	a_fire_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tick && fire |=> elapsed_q == '0 && fired_q)
		else $error("step did not clear tick count");

	// divider is never relaunched while it is working
	a_div_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !div_busy)
		else $error("divider launched while busy");

endmodule

`default_nettype wire

// ----- design/sarg_ctrl.sv -----
// sequencer of one tick: target check, ramp recompute, tick count, result
// depends on sarg_pkg for command and status types
`default_nettype none

module sarg_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           in_valid,
	input  wire logic           out_free,
	input  wire sarg_pkg::sts_t sts,
	output sarg_pkg::cmd_t      cmd,
	output logic                idle
);

	typedef enum logic [9:0] {
		ST_IDLE   = 10'b00_0000_0001,
		ST_DIST   = 10'b00_0000_0010,
		ST_ABS    = 10'b00_0000_0100,
		ST_DECIDE = 10'b00_0000_1000,
		ST_APPLY  = 10'b00_0001_0000,
		ST_DIVIDE = 10'b00_0010_0000,
		ST_UPDATE = 10'b00_0100_0000,
		ST_LOAD   = 10'b00_1000_0000,
		ST_TICK   = 10'b01_0000_0000,
		ST_EMIT   = 10'b10_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   phase_q, phase_d;  // 0: after target change, 1: after step
	state_t after_ramp;

	always_comb begin
		after_ramp = phase_q ? ST_EMIT : ST_TICK;
		state_d    = state_q;
		phase_d    = phase_q;
		cmd        = '0;
		idle       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				idle = 1'b1;
				if (in_valid) begin
					cmd.take = 1'b1;
					phase_d  = 1'b0;
					state_d  = ST_DIST;
				end
			end
			ST_DIST: begin
				cmd.span = 1'b1;
				if (phase_q ? sts.fired : sts.changed)
					state_d = ST_ABS;
				else
					state_d = after_ramp;
			end
			ST_ABS: begin
				cmd.absd = 1'b1;
				state_d  = ST_DECIDE;
			end
			ST_DECIDE: begin
				cmd.decide = 1'b1;
				state_d    = ST_APPLY;
			end
			ST_APPLY: begin
				if (sts.kind == sarg_pkg::KIND_DIV) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIVIDE;
				end else begin
					cmd.apply = 1'b1;
					state_d   = after_ramp;
				end
			end
			ST_DIVIDE: begin
				if (sts.div_done)
					state_d = ST_UPDATE;
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_d    = ST_LOAD;
			end
			ST_LOAD: begin
				cmd.load = 1'b1;
				state_d  = after_ramp;
			end
			ST_TICK: begin
				cmd.tick = 1'b1;
				phase_d  = 1'b1;
				state_d  = ST_DIST;
			end
			ST_EMIT: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

endmodule

`default_nettype wire

// ----- tb/stepper_accel_ramp_generator_tb.sv -----
// self-checking testbench for the stepper acceleration ramp generator
// depends on sarg_pkg and stepper_accel_ramp_generator; predicts every tick result
// from its ramp predictor or a hand-typed row; compares field by field in request order

module stepper_accel_ramp_generator_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int FRAC_BITS       = 8;
	localparam int RESET_CYCLES    = 9;
	localparam int WATCHDOG_LIMIT  = 4000;
	localparam int HOLD_OFF_CYCLES = 400;
	localparam int TAIL_CYCLES     = 100;
	localparam int NUM_PHASES      = 8;
	localparam int ITEMS_PER_PHASE = 190;
	localparam int PRESSURE_PHASE  = 4;
	localparam longint INDEX_LIMIT = 64'sd2147483647;

	// one tick result as seen on the output ports
	typedef struct packed {
		logic                                pulse;
		logic                                dir;
		logic signed [sarg_pkg::IO_POS_BITS-1:0] pos;
		logic                                run;
		logic [sarg_pkg::MAG_BITS-1:0]       mag;
	} motion_report_t;

	// directed script: either a tick request or a register write
	typedef enum logic {
		ROW_TICK,
		ROW_WRITE
	} row_kind_t;

	typedef struct {
		row_kind_t                         kind;
		logic [sarg_pkg::CFG_IDX_BITS-1:0] idx;
		logic [31:0]                       value;
		bit                                typed;
		motion_report_t                    rep;
	} script_row_t;

	// dut ports
	logic                                    clk;
	logic                                    arst_n;
	logic                                    cfg_valid;
	logic                                    cfg_ready;
	logic [sarg_pkg::CFG_IDX_BITS-1:0]       cfg_index;
	logic [sarg_pkg::CFG_DATA_BITS-1:0]      cfg_data;
	logic                                    in_valid;
	logic                                    in_stall;
	logic signed [sarg_pkg::IO_POS_BITS-1:0] target_position;
	logic                                    out_valid;
	logic                                    out_stall;
	logic                                    step_pulse;
	logic                                    direction_out;
	logic signed [sarg_pkg::IO_POS_BITS-1:0] position;
	logic                                    running;
	logic [sarg_pkg::MAG_BITS-1:0]           steps_to_stop;

	// hand-typed result travelling with the offered request
	bit             row_typed;
	motion_report_t row_report;

	// idling controls
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;
	int holds_asked = 0;
	int holds_done = 0;

	// predicted results still owed by the block, oldest first
	motion_report_t motion_reports[$];
	int mismatch_count = 0;
	int quiet_cycles = 0;
	script_row_t script[$];

	// predictor copy of the configuration
	logic [31:0] c0_q  = sarg_pkg::INITIAL_INTERVAL_RESET;
	logic [31:0] min_q = sarg_pkg::MIN_INTERVAL_RESET;

	// predictor copy of the motion state
	logic signed [31:0]               pos_q = '0;
	logic signed [31:0]               goal_q = '0;
	longint                           ramp_n_q = 0;
	logic [31:0]                      cn_q = '0;
	logic [sarg_pkg::TICK_BITS-1:0]   interval_us_q = '0;
	logic [sarg_pkg::TICK_BITS-1:0]   elapsed_q = '0;
	logic                             cw_q = 1'b0;

	stepper_accel_ramp_generator u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_valid      (cfg_valid),
		.cfg_ready      (cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.target_position(target_position),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.step_pulse     (step_pulse),
		.direction_out  (direction_out),
		.position       (position),
		.running        (running),
		.steps_to_stop  (steps_to_stop)
	);

	// 8 ns clock
	always begin
		clk = 1'b0;
		#4;
		clk = 1'b1;
		#4;
	end

	// ramp index saturates symmetrically
	function automatic longint clamp_index(input longint n);
		if (n > INDEX_LIMIT) return INDEX_LIMIT;
		if (n < -INDEX_LIMIT) return -INDEX_LIMIT;
		return n;
	endfunction

	// whole microseconds of a fixed-point interval, saturated to the tick counter
	function automatic logic [sarg_pkg::TICK_BITS-1:0] whole_us(input logic [31:0] cn);
		logic [31:0] w;
		w = cn >> FRAC_BITS;
		return (w > sarg_pkg::TICK_MAX) ? sarg_pkg::TICK_MAX : w[sarg_pkg::TICK_BITS-1:0];
	endfunction

	// new target or fired step: decide direction and next interval
	task automatic recompute_ramp_model();
		longint      span;
		longint      n;
		logic [63:0] den;
		logic [63:0] quo;
		logic [63:0] sum;
		span = longint'(goal_q) - longint'(pos_q);
		n = ramp_n_q;
		// arrived with n at most one: stop, cn is kept
		if (span == 0 && n <= 1) begin
			interval_us_q = '0;
			ramp_n_q = 0;
			return;
		end
		// negate +n when distance <= n or motion points away, -n when neither holds
		if (span > 0) begin
			if (n > 0) begin
				if (n >= span || !cw_q) n = -n;
			end else if (n < 0) begin
				if (-n < span && cw_q) n = -n;
			end
		end else if (span < 0) begin
			if (n > 0) begin
				if (n >= -span || cw_q) n = -n;
			end else if (n < 0) begin
				if (-n < -span && !cw_q) n = -n;
			end
		end
		n = clamp_index(n);
		if (n == 0) begin
			// first step of a ramp
			cn_q = c0_q;
			cw_q = (span > 0);
			interval_us_q = whole_us(cn_q);
			n = 1;
		end else if (n > 0) begin
			// accelerate until the interval reaches min_interval, then cruise
			if (({40'd0, interval_us_q} << FRAC_BITS) > {32'd0, min_q}) begin
				den = 64'(4 * n + 1);
				quo = {31'd0, cn_q, 1'b0} / den;
				cn_q = cn_q - quo[31:0];
				interval_us_q = whole_us(cn_q);
				n = clamp_index(n + 1);
			end
		end else begin
			// decelerate, interval grows and saturates
			den = 64'(-(4 * n + 1));
			quo = {31'd0, cn_q, 1'b0} / den;
			sum = {32'd0, cn_q} + quo;
			cn_q = (sum > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : sum[31:0];
			interval_us_q = whole_us(cn_q);
			n = clamp_index(n + 1);
		end
		ramp_n_q = n;
	endtask

	// one microsecond tick of the motor model
	task automatic advance_motor_tick(input logic signed [31:0] tgt, output motion_report_t rep);
		logic   pulse;
		longint mag;
		pulse = 1'b0;
		if (tgt != goal_q) begin
			goal_q = tgt;
			recompute_ramp_model();
		end
		if (elapsed_q < sarg_pkg::TICK_MAX) elapsed_q = elapsed_q + 1'b1;
		if (interval_us_q != 0 && elapsed_q >= interval_us_q) begin
			pos_q = cw_q ? pos_q + 32'sd1 : pos_q - 32'sd1;
			elapsed_q = '0;
			pulse = 1'b1;
			recompute_ramp_model();
		end
		mag = (ramp_n_q < 0) ? -ramp_n_q : ramp_n_q;
		rep.pulse = pulse;
		rep.dir = cw_q;
		rep.pos = pos_q;
		rep.run = (interval_us_q != 0);
		rep.mag = mag[sarg_pkg::MAG_BITS-1:0];
	endtask

	function automatic bit field_matches(input string name, input logic signed [63:0] want,
			input logic signed [63:0] got);
		if (got !== want) begin
			$display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
			return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void add_row(input row_kind_t kind,
			input logic [sarg_pkg::CFG_IDX_BITS-1:0] idx, input logic [31:0] value,
			input bit typed, input motion_report_t rep);
		script_row_t r;
		r.kind = kind;
		r.idx = idx;
		r.value = value;
		r.typed = typed;
		r.rep = rep;
		script.push_back(r);
	endfunction

	// offer one tick request, idling first as the current phase asks
	task automatic offer_tick(input logic [31:0] tgt, input bit typed, input motion_report_t rep);
		while (tx_idle_pct != 0 && $urandom_range(1, 100) <= tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		target_position <= tgt;
		row_typed <= typed;
		row_report <= rep;
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	// wait until every request has its result back, then write one register
	task automatic write_reg(input logic [sarg_pkg::CFG_IDX_BITS-1:0] idx, input logic [31:0] val);
		in_valid <= 1'b0;
		do @(negedge clk); while (motion_reports.size() != 0);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
	endtask

	// result side: random stall, or a long counted hold-off when asked
	initial begin : receiver
		int held;
		out_stall = 1'b0;
		forever begin
			@(posedge clk);
			if (holds_asked != holds_done) begin
				out_stall <= 1'b1;
				for (held = 0; held < HOLD_OFF_CYCLES; held++) @(posedge clk);
				holds_done <= holds_done + 1;
			end else begin
				out_stall <= (rx_stall_pct != 0) && ($urandom_range(1, 100) <= rx_stall_pct);
			end
		end
	end

	// scoreboard: results are checked before the same-edge request is predicted
	always @(posedge clk) begin : scoreboard
		motion_report_t seen;
		motion_report_t want;
		motion_report_t model;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				seen.pulse = step_pulse;
				seen.dir = direction_out;
				seen.pos = position;
				seen.run = running;
				seen.mag = steps_to_stop;
				if (motion_reports.size() == 0) begin
					$display("%0t: result with no request outstanding, position %0d", $time,
						position);
					mismatch_count++;
				end else begin
					want = motion_reports.pop_front();
					if (!(field_matches("step_pulse", want.pulse, seen.pulse)
							& field_matches("direction_out", want.dir, seen.dir)
							& field_matches("position", $signed(want.pos), $signed(seen.pos))
							& field_matches("running", want.run, seen.run)
							& field_matches("steps_to_stop", want.mag, seen.mag)))
						mismatch_count++;
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					sarg_pkg::REG_INITIAL_INTERVAL: c0_q = cfg_data;
					sarg_pkg::REG_MIN_INTERVAL:     min_q = cfg_data;
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				// the model always advances; a typed row overrides its answer
				advance_motor_tick(target_position, model);
				motion_reports.push_back(row_typed ? row_report : model);
			end
		end
	end

	// watchdog on cycles with no handshake of any kind
	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
				|| (cfg_valid && cfg_ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, quiet_cycles);
			$display("tb: failure");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		int                 i;
		int                 k;
		int                 ph;
		int                 hold_left;
		int                 pick;
		bit                 noise;
		logic signed [31:0] aim;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		target_position = '0;
		row_typed = 1'b0;
		row_report = '0;
		hold_left = 0;
		noise = 1'b0;
		aim = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset configuration first: c0 is zero
		// after reset nothing moves and every field reads zero
		add_row(ROW_TICK, '0, 32'd0, 1'b1, '0);
		// zero c0: ramp starts clockwise with n = 1 but never runs
		for (i = 0; i < 2; i++)
			add_row(ROW_TICK, '0, 32'h7FFF_FFFF, 1'b1,
				'{pulse: 1'b0, dir: 1'b1, pos: 32'sd0, run: 1'b0, mag: 31'd1});
		// most negative target, distance taken without wrap
		for (i = 0; i < 2; i++) add_row(ROW_TICK, '0, 32'h8000_0000, 1'b0, '0);
		add_row(ROW_TICK, '0, 32'd0, 1'b0, '0);
		// 3 us start, 1 us floor: restart after a pause, accel, decel, stop at target
		add_row(ROW_WRITE, sarg_pkg::REG_INITIAL_INTERVAL, 32'h0000_0300, 1'b0, '0);
		add_row(ROW_WRITE, sarg_pkg::REG_MIN_INTERVAL, 32'h0000_0100, 1'b0, '0);
		for (i = 0; i < 6; i++) add_row(ROW_TICK, '0, 32'd3, 1'b0, '0);
		// reversal through zero
		for (i = 0; i < 4; i++) add_row(ROW_TICK, '0, -32'sd2, 1'b0, '0);
		// floor at its maximum: cruise at c0 from the first step
		add_row(ROW_WRITE, sarg_pkg::REG_MIN_INTERVAL, 32'hFFFF_FFFF, 1'b0, '0);
		for (i = 0; i < 3; i++) add_row(ROW_TICK, '0, 32'd1, 1'b0, '0);
		// largest c0: interval saturates, no step comes
		add_row(ROW_WRITE, sarg_pkg::REG_INITIAL_INTERVAL, 32'hFFFF_FFFF, 1'b0, '0);
		for (i = 0; i < 2; i++) add_row(ROW_TICK, '0, 32'd100, 1'b0, '0);
		// zero floor, fastest start
		add_row(ROW_WRITE, sarg_pkg::REG_MIN_INTERVAL, 32'h0000_0000, 1'b0, '0);
		add_row(ROW_WRITE, sarg_pkg::REG_INITIAL_INTERVAL, 32'h0000_0100, 1'b0, '0);
		for (i = 0; i < 4; i++) add_row(ROW_TICK, '0, 32'd2, 1'b0, '0);

		foreach (script[i]) begin
			if (script[i].kind == ROW_WRITE)
				write_reg(script[i].idx, script[i].value);
			else
				offer_tick(script[i].value, script[i].typed, script[i].rep);
		end

		// random phases: new ramp settings and a new idling pattern each time
		for (ph = 0; ph < NUM_PHASES; ph++) begin
			// intervals mostly up to 16 us so steps are frequent; last phase spans all sizes
			write_reg(sarg_pkg::REG_INITIAL_INTERVAL,
				$urandom() >> ((ph == NUM_PHASES - 1) ? $urandom_range(0, 24)
					: $urandom_range(20, 23)));
			write_reg(sarg_pkg::REG_MIN_INTERVAL, $urandom_range(0, 32'h400));
			case (ph % 4)
				0: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 0;
				end
				1: begin
					tx_idle_pct = 88;
					rx_stall_pct <= 0;
				end
				2: begin
					tx_idle_pct = 0;
					rx_stall_pct <= 88;
				end
				default: begin
					tx_idle_pct = 28;
					rx_stall_pct <= 28;
				end
			endcase
			// long hold-off on the result side while requests keep coming
			if (ph == PRESSURE_PHASE) holds_asked <= holds_asked + 1;

			for (k = 0; k < ITEMS_PER_PHASE; k++) begin
				if (hold_left == 0) begin
					pick = $urandom_range(0, 99);
					noise = (pick < 8);
					if (pick < 8) begin
						// one stray tick with any target at all
						hold_left = 1;
					end else if (pick < 20) begin
						// sit on the target long enough to come to rest
						hold_left = $urandom_range(60, 150);
					end else begin
						// short move near the current aim
						aim = aim + int'($urandom_range(0, 32)) - 16;
						hold_left = $urandom_range(1, 40);
					end
				end
				offer_tick(noise ? $urandom() : aim, 1'b0, '0);
				hold_left--;
			end
		end

		// drain, then give the block time to show any stray result
		in_valid <= 1'b0;
		do @(negedge clk); while (motion_reports.size() != 0);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (motion_reports.size() != 0)
			$display("%0t: %0d results never arrived", $time, motion_reports.size());
		if (mismatch_count == 0 && motion_reports.size() == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule
